/* rtl/core/epfc_pkg.sv */
// shared constants, codes and word types for the edge page fifo cache
`default_nettype none

package epfc_pkg;

  // cache geometry
  localparam int CacheSlots = 16;
  localparam int PageIdBits = 16;
  localparam int SlotBits   = 4;
  localparam int CountBits  = 5;
  localparam int TotalBits  = 32;

  // lookup outcome of one edge
  typedef enum logic [2:0] {
    HitBoth    = 3'd0,
    HitSrcOnly = 3'd1,
    HitDstOnly = 3'd2,
    MissSame   = 3'd3,
    MissTwo    = 3'd4
  } hit_case_e;

  // input word: one graph edge
  typedef struct packed {
    logic [PageIdBits-1:0] src_page;
    logic [PageIdBits-1:0] dst_page;
  } epfc_in_t;

  // result word
  typedef struct packed {
    logic [2:0]           hit_case;
    logic [1:0]           pages_loaded;
    logic [SlotBits-1:0]  first_slot;
    logic [SlotBits-1:0]  second_slot;
    logic                 skipped;
    logic [TotalBits-1:0] fill_total;
    logic [TotalBits-1:0] skip_total;
  } epfc_out_t;

endpackage

`default_nettype wire

/* rtl/core/edge_page_fifo_cache.sv */
// edge page fifo cache: fully associative page tags with fifo replacement
//
//  channel | direction | handshake               | word
//  in      | input     | in_valid_i / in_stall_o | src_page, dst_page
//  out     | output    | out_valid_o/out_stall_i | hit case, fills, slots, totals
//  cfg     | input     | cfg_valid_i/cfg_ready_o | slots_in_use (5 bits)
//
// one edge per cycle sustained unless the output stalls; an edge is held in the
// input register, then the tag compare, victim choice and state update run
// combinationally into the result register, from which the result is presented.
// reset clears valid bits, pointer and totals at once; no clearing pass.
// a stalled result holds the result register and, through it, the input register.
`default_nettype none

module edge_page_fifo_cache (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire epfc_pkg::epfc_in_t                  in_word_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output epfc_pkg::epfc_out_t                      out_word_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [epfc_pkg::CountBits-1:0]      cfg_data_i
);

  import epfc_pkg::*;

  logic                  in_valid_q;
  epfc_in_t              in_word_q;
  logic                  out_valid_q;
  epfc_out_t             out_word_q;
  logic [CountBits-1:0]  slots_cfg_q;
  logic [PageIdBits-1:0] tag_q [CacheSlots];
  logic [CacheSlots-1:0] tag_valid_q;
  logic [SlotBits-1:0]   ptr_q;
  logic [TotalBits-1:0]  fill_cnt_q;
  logic [TotalBits-1:0]  skip_cnt_q;

  logic                  adv;
  logic                  fire;
  logic [CountBits-1:0]  n_active;
  logic [SlotBits-1:0]   ptr0;
  logic [SlotBits-1:0]   ptr1;
  logic [SlotBits-1:0]   ptr2;
  logic [CacheSlots-1:0] src_match;
  logic [CacheSlots-1:0] dst_match;
  logic                  src_hit;
  logic                  dst_hit;
  logic                  skip;
  logic                  we_a;
  logic                  we_b;
  logic [SlotBits-1:0]   slot_a;
  logic [SlotBits-1:0]   slot_b;
  logic [PageIdBits-1:0] page_a;
  logic [PageIdBits-1:0] page_b;
  logic [SlotBits-1:0]   ptr_d;
  hit_case_e             hcase;
  logic [1:0]            loaded;
  epfc_out_t             out_word_d;

  // pointer step with wrap at the active slot count
  function automatic logic [SlotBits-1:0] step_ptr(input logic [SlotBits-1:0] p,
                                                   input logic [CountBits-1:0] n);
    logic [CountBits-1:0] nxt;
    nxt = {1'b0, p} + CountBits'(1);
    if (nxt >= n) begin
      return '0;
    end
    return nxt[SlotBits-1:0];
  endfunction

  // handshakes
  assign adv         = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_q && adv;
  assign in_stall_o  = in_valid_q && !adv;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // active slot count, clamped to one..CacheSlots
  always_comb begin
    n_active = slots_cfg_q;
    if (slots_cfg_q == '0) begin
      n_active = CountBits'(1);
    end else if (slots_cfg_q > CountBits'(CacheSlots)) begin
      n_active = CountBits'(CacheSlots);
    end
  end

  // pointer brought back in range after the slot count was lowered
  assign ptr0 = ({1'b0, ptr_q} >= n_active) ? '0 : ptr_q;

  // parallel tag compare over the active slots
  always_comb begin
    for (int i = 0; i < CacheSlots; i++) begin
      src_match[i] = tag_valid_q[i] && (tag_q[i] == in_word_q.src_page)
                     && (CountBits'(i) < n_active);
      dst_match[i] = tag_valid_q[i] && (tag_q[i] == in_word_q.dst_page)
                     && (CountBits'(i) < n_active);
    end
  end

  assign src_hit = |src_match;
  assign dst_hit = |dst_match;

  // victim choice: skip a slot that holds the page that hit
  always_comb begin
    hcase  = HitBoth;
    loaded = 2'd0;
    skip   = 1'b0;
    we_a   = 1'b0;
    we_b   = 1'b0;
    slot_a = ptr0;
    slot_b = ptr0;
    page_a = in_word_q.src_page;
    page_b = in_word_q.dst_page;
    ptr1   = step_ptr(ptr0, n_active);
    ptr_d  = ptr0;
    ptr2   = ptr1;
    if (src_hit && dst_hit) begin
      hcase = HitBoth;
    end else if (src_hit || dst_hit) begin
      hcase  = src_hit ? HitSrcOnly : HitDstOnly;
      skip   = src_hit ? src_match[ptr0] : dst_match[ptr0];
      ptr2   = skip ? ptr1 : ptr0;
      we_a   = 1'b1;
      slot_a = ptr2;
      page_a = src_hit ? in_word_q.dst_page : in_word_q.src_page;
      loaded = 2'd1;
      ptr_d  = step_ptr(ptr2, n_active);
    end else if (in_word_q.src_page == in_word_q.dst_page) begin
      hcase  = MissSame;
      we_a   = 1'b1;
      slot_a = ptr0;
      page_a = in_word_q.dst_page;
      loaded = 2'd1;
      ptr_d  = ptr1;
    end else begin
      hcase  = MissTwo;
      we_a   = 1'b1;
      we_b   = 1'b1;
      slot_a = ptr0;
      slot_b = ptr1;
      loaded = 2'd2;
      ptr_d  = step_ptr(ptr1, n_active);
    end
  end

  // result word
  always_comb begin
    out_word_d              = '0;
    out_word_d.hit_case     = hcase;
    out_word_d.pages_loaded = loaded;
    out_word_d.first_slot   = we_a ? slot_a : '0;
    out_word_d.second_slot  = we_b ? slot_b : '0;
    out_word_d.skipped      = skip;
    out_word_d.fill_total   = fill_cnt_q + TotalBits'(loaded);
    out_word_d.skip_total   = skip_cnt_q + TotalBits'(skip);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      slots_cfg_q <= CountBits'(CacheSlots);
      tag_valid_q <= '0;
      ptr_q       <= '0;
      fill_cnt_q  <= '0;
      skip_cnt_q  <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        slots_cfg_q <= cfg_data_i;
      end
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
      if (fire) begin
        ptr_q      <= ptr_d;
        fill_cnt_q <= out_word_d.fill_total;
        skip_cnt_q <= out_word_d.skip_total;
        for (int i = 0; i < CacheSlots; i++) begin
          if ((we_a && slot_a == SlotBits'(i)) || (we_b && slot_b == SlotBits'(i))) begin
            tag_valid_q[i] <= 1'b1;
          end
        end
      end
    end
  end

  // payload registers and tag store; second fill wins on a shared slot
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q <= in_word_i;
    end
    if (fire) begin
      out_word_q <= out_word_d;
      for (int i = 0; i < CacheSlots; i++) begin
        if (we_b && slot_b == SlotBits'(i)) begin
          tag_q[i] <= page_b;
        end else if (we_a && slot_a == SlotBits'(i)) begin
          tag_q[i] <= page_a;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// self-checking testbench for the edge page fifo cache with its own tag and pointer model

module testbench;
  import epfc_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int SettleCycles  = 4;
  localparam int RandomEdges   = 1000;
  localparam int RandomPhases  = 8;
  localparam int HoldCycles    = 300;
  localparam int PoolDepth     = 24;

  // clock, reset and block ports
  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  epfc_in_t             in_word_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  epfc_out_t            out_word_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CountBits-1:0] cfg_data_i  = '0;

  edge_page_fifo_cache i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  // tag model state, as after reset
  logic [PageIdBits-1:0] tag_q [CacheSlots];
  bit   [CacheSlots-1:0] tag_valid  = '0;
  int                    victim_ptr = 0;
  logic [TotalBits-1:0]  fill_cnt   = '0;
  logic [TotalBits-1:0]  skip_cnt   = '0;
  logic [CountBits-1:0]  slots_reg  = CountBits'(CacheSlots);

  // predicted result words, oldest first
  epfc_out_t lookup_results_q [$];

  // run bookkeeping
  int fail_count     = 0;
  int edges_sent     = 0;
  int results_seen   = 0;
  int cfg_writes     = 0;
  int case_tally [5] = '{default: 0};

  // pacing of both sides, and the long output hold-off request
  bit pacing       = 1'b1;
  int hold_req     = 0;
  int hold_seen    = 0;
  int hold_left    = 0;
  int burst_left   = 0;
  bit burst_stall  = 1'b0;
  int idle_cycles  = 0;

  // random page pool, small enough to give plenty of hits
  logic [PageIdBits-1:0] page_pool [PoolDepth];
  int                    pool_used = 4;

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // is the page held in a valid slot below the slot count
  function automatic bit page_held(input logic [PageIdBits-1:0] page, input int n);
    for (int i = 0; i < n; i++) begin
      if (tag_valid[i] && tag_q[i] == page) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void advance_ptr(input int n);
    victim_ptr = (victim_ptr + 1 >= n) ? 0 : victim_ptr + 1;
  endfunction

  // write the page at the victim slot and move on
  function automatic logic [SlotBits-1:0] fill_page(input logic [PageIdBits-1:0] page,
                                                     input int n);
    logic [SlotBits-1:0] slot;
    slot = victim_ptr[SlotBits-1:0];
    tag_q[victim_ptr]     = page;
    tag_valid[victim_ptr] = 1'b1;
    fill_cnt++;
    advance_ptr(n);
    return slot;
  endfunction

  // step over the victim slot when it holds the page that hit
  function automatic logic step_over(input logic [PageIdBits-1:0] page, input int n);
    if (tag_valid[victim_ptr] && tag_q[victim_ptr] == page) begin
      skip_cnt++;
      advance_ptr(n);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // expected result word of one edge, updating the model state
  function automatic epfc_out_t predict_edge(input epfc_in_t e);
    epfc_out_t r;
    int        n;
    bit        src_hit;
    bit        dst_hit;
    n = (slots_reg == 0) ? 1 : ((slots_reg > CacheSlots) ? CacheSlots : int'(slots_reg));
    if (victim_ptr >= n) victim_ptr = 0;
    src_hit = page_held(e.src_page, n);
    dst_hit = page_held(e.dst_page, n);
    r = '0;
    if (src_hit && dst_hit) begin
      r.hit_case = HitBoth;
    end else if (src_hit) begin
      r.hit_case     = HitSrcOnly;
      r.skipped      = step_over(e.src_page, n);
      r.first_slot   = fill_page(e.dst_page, n);
      r.pages_loaded = 2'd1;
    end else if (dst_hit) begin
      r.hit_case     = HitDstOnly;
      r.skipped      = step_over(e.dst_page, n);
      r.first_slot   = fill_page(e.src_page, n);
      r.pages_loaded = 2'd1;
    end else if (e.src_page == e.dst_page) begin
      r.hit_case     = MissSame;
      r.first_slot   = fill_page(e.dst_page, n);
      r.pages_loaded = 2'd1;
    end else begin
      r.hit_case     = MissTwo;
      r.first_slot   = fill_page(e.src_page, n);
      r.second_slot  = fill_page(e.dst_page, n);
      r.pages_loaded = 2'd2;
    end
    r.fill_total = fill_cnt;
    r.skip_total = skip_cnt;
    case_tally[r.hit_case]++;
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (!pacing) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [PageIdBits-1:0] pick_page();
    if ($urandom_range(0, 99) < 85) return page_pool[$urandom_range(0, pool_used - 1)];
    return PageIdBits'($urandom_range(0, (1 << PageIdBits) - 1));
  endfunction

  // offer one edge word and wait for it to be taken
  task automatic send_edge(input logic [PageIdBits-1:0] src, input logic [PageIdBits-1:0] dst);
    int        gap;
    epfc_out_t predicted;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{src_page: src, dst_page: dst};
    do @(posedge clk_i); while (in_stall_o);
    predicted        = predict_edge(in_word_i);
    lookup_results_q = {lookup_results_q, predicted};
    edges_sent++;
  endtask

  // drop the input and wait for every predicted word to come out
  task automatic settle_pipeline();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (lookup_results_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // slot count write, only called with the block idle
  task automatic write_slot_count(input logic [CountBits-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    slots_reg = value;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // cold cache at the reset slot count: every lookup outcome
  task automatic test_after_reset();
    send_edge(16'h0000, 16'h0000);
    send_edge(16'hFFFF, 16'h0000);
    send_edge(16'h0000, 16'hFFFF);
    send_edge(16'h0000, 16'h1234);
    send_edge(16'hA5A5, 16'h5A5A);
    settle_pipeline();
  endtask

  // two slots: pointer out of range after lowering, victim skip, lookup scope
  task automatic test_victim_skip();
    write_slot_count(5'd2);
    send_edge(16'h0000, 16'h0BEE);
    send_edge(16'h0C0C, 16'h0BEE);
    send_edge(16'h0D0D, 16'h0BEE);
    send_edge(16'h1234, 16'h0D0D);
    settle_pipeline();
  endtask

  // one slot: skip wraps back onto slot 0, a two-page fill hits slot 0 twice
  task automatic test_single_slot();
    write_slot_count(5'd1);
    send_edge(16'h0E0E, 16'h0E0E);
    send_edge(16'h0E0E, 16'h0F0F);
    send_edge(16'h0F0F, 16'h0F0F);
    send_edge(16'h1111, 16'h2222);
    settle_pipeline();
  endtask

  // zero count acts as one, counts above the cache size saturate
  task automatic test_slot_count_limits();
    write_slot_count(5'd0);
    send_edge(16'h3333, 16'h2222);
    send_edge(16'h3333, 16'h3333);
    settle_pipeline();
    write_slot_count(5'd31);
    send_edge(16'hFFFF, 16'h3333);
    send_edge(16'h7777, 16'h8888);
    settle_pipeline();
    write_slot_count(5'd17);
    send_edge(16'h8888, 16'h9999);
    send_edge(16'h4444, 16'h4444);
    settle_pipeline();
  endtask

  // hold the output off for a long stretch while edges keep coming
  task automatic test_backpressure();
    write_slot_count(5'd16);
    hold_req++;
    repeat (12) send_edge(PageIdBits'($urandom_range(0, 7)), PageIdBits'($urandom_range(0, 7)));
    settle_pipeline();
  endtask

  // random edge stream over several slot counts, some phases without idling
  task automatic test_random_edges();
    logic [CountBits-1:0]  count;
    logic [PageIdBits-1:0] src;
    int                    eff;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      case (phase)
        0:       count = 5'd16;
        1:       count = 5'd1;
        2:       count = 5'd0;
        3:       count = 5'd31;
        4:       count = 5'd2;
        5:       count = CountBits'($urandom_range(17, 31));
        default: count = CountBits'($urandom_range(1, 16));
      endcase
      write_slot_count(count);
      eff       = (count == 0) ? 1 : ((count > CacheSlots) ? CacheSlots : int'(count));
      pool_used = eff + 4;
      page_pool[0] = '0;
      page_pool[1] = '1;
      for (int i = 2; i < PoolDepth; i++) begin
        page_pool[i] = PageIdBits'($urandom_range(0, (1 << PageIdBits) - 1));
      end
      pacing = (phase % 3 != 1);
      repeat (RandomEdges / RandomPhases) begin
        src = pick_page();
        send_edge(src, ($urandom_range(0, 9) == 0) ? src : pick_page());
      end
      settle_pipeline();
    end
    pacing = 1'b1;
  endtask

  // output side: random stall bursts, and the long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (!pacing) begin
      out_stall_i <= 1'b0;
    end else begin
      if (burst_left == 0) begin
        burst_stall = ($urandom_range(0, 99) < 40);
        if (!burst_stall) burst_left = $urandom_range(1, 6);
        else if ($urandom_range(0, 99) < 85) burst_left = $urandom_range(1, 3);
        else burst_left = $urandom_range(8, 30);
      end
      burst_left--;
      out_stall_i <= burst_stall;
    end
  end

  // compare each result word taken with the oldest prediction
  always @(posedge clk_i) begin
    epfc_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (lookup_results_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result word: case %0d loaded %0d fills %0d",
                   out_word_o.hit_case, out_word_o.pages_loaded, out_word_o.fill_total);
        end
      end else begin
        want = lookup_results_q[0];
        lookup_results_q.delete(0);
        results_seen++;
        if (out_word_o.hit_case !== want.hit_case ||
            out_word_o.pages_loaded !== want.pages_loaded ||
            out_word_o.first_slot !== want.first_slot ||
            out_word_o.second_slot !== want.second_slot ||
            out_word_o.skipped !== want.skipped ||
            out_word_o.fill_total !== want.fill_total ||
            out_word_o.skip_total !== want.skip_total) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display({"result %0d: expected case %0d loaded %0d slots %0d/%0d",
                      " skip %0d totals %0d/%0d"},
                     results_seen, want.hit_case, want.pages_loaded, want.first_slot,
                     want.second_slot, want.skipped, want.fill_total, want.skip_total);
            $display({"result %0d: got      case %0d loaded %0d slots %0d/%0d",
                      " skip %0d totals %0d/%0d"},
                     results_seen, out_word_o.hit_case, out_word_o.pages_loaded,
                     out_word_o.first_slot, out_word_o.second_slot, out_word_o.skipped,
                     out_word_o.fill_total, out_word_o.skip_total);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 idle_cycles, lookup_results_q.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_after_reset();
    test_victim_skip();
    test_single_slot();
    test_slot_count_limits();
    test_backpressure();
    test_random_edges();
    $display({"%0d edges: %0d both hit, %0d src hit, %0d dst hit,",
              " %0d same-page miss, %0d two-page miss"},
             edges_sent, case_tally[HitBoth], case_tally[HitSrcOnly], case_tally[HitDstOnly],
             case_tally[MissSame], case_tally[MissTwo]);
    $display("%0d results checked, %0d slot count writes, %0d victim skips, %0d mismatches",
             results_seen, cfg_writes, skip_cnt, fail_count);
    if (fail_count == 0 && lookup_results_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/epfc_pkg.sv
rtl/core/edge_page_fifo_cache.sv
test/testbench.sv
